/* hdl/eldb_pkg.sv */
// eldb_pkg: shared types and codes for the error log dedup buffer
// holds transfer structs, command and status codes, fsm state type
// no dependencies
package eldb_pkg;

	localparam logic [1:0] CMD_LOG   = 2'd0;
	localparam logic [1:0] CMD_DRAIN = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam logic [2:0] ST_LOGGED  = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_DUP     = 3'd3;
	localparam logic [2:0] ST_ENTRY   = 3'd4;
	localparam logic [2:0] ST_EMPTY   = 3'd5;
	localparam logic [2:0] ST_CLEARED = 3'd6;

	localparam int CODE_W  = 16;
	localparam int COUNT_W = 6;

	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [CODE_W-1:0] err_code;
	} eldb_in_t;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [CODE_W-1:0] code;
		logic [COUNT_W-1:0]       count;
		logic                     last;
	} eldb_out_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_FIN,
		S_DRAIN,
		S_DRAIN_END
	} eldb_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       idx_scan;
		logic       idx_zero;
		logic       rd_issue;
		logic       append;
		logic       clr_cnt;
		logic       emit;
		logic [2:0] emit_st;
	} eldb_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic code_zero;
		logic full;
		logic gt_win;
		logic empty;
		logic at_end;
		logic dup;
		logic rvalid;
	} eldb_stat_t;

endpackage

/* hdl/eldb_ram.sv */
// eldb_ram: generic single write port, single read port ram
// registered read data; no package dependency
module eldb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/eldb_datapath.sv */
// eldb_datapath: code store, count, read index, compare and result register
// depends on eldb_pkg and eldb_ram
module eldb_datapath
	import eldb_pkg::*;
#(
	parameter int DEPTH  = 32,
	parameter int WINDOW = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  eldb_in_t   item,
	input  eldb_cmd_t  dp_cmd,
	output eldb_stat_t dp_stat,
	output logic       strobe,
	output eldb_out_t  result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]            cnt_q;
	logic [AW-1:0]            idx_q;
	logic signed [CODE_W-1:0] code_q;
	logic                     hit_q;
	logic                     rvalid_q;
	logic                     rlast_q;
	logic                     strobe_q;
	eldb_out_t                result_q;
	logic [CODE_W-1:0]        rdata;
	logic                     match;
	eldb_out_t                res_d;
	logic signed [CODE_W-1:0] wr_code;

	// a log with no scan appends in its transfer cycle, before code_q is loaded
	assign wr_code = dp_cmd.capture ? item.err_code : code_q;

	eldb_ram #(
		.WIDTH(CODE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (dp_cmd.append),
		.waddr(AW'(cnt_q)),
		.wdata(wr_code),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign match = rvalid_q && (rdata == code_q);

	always_comb begin
		dp_stat.code_zero = (item.err_code == '0);
		dp_stat.full      = (32'(cnt_q) >= 32'(DEPTH));
		dp_stat.gt_win    = (32'(cnt_q) > 32'(WINDOW));
		dp_stat.empty     = (cnt_q == '0);
		dp_stat.at_end    = (CW'(idx_q) == cnt_q - CW'(1));
		dp_stat.dup       = hit_q || match;
		dp_stat.rvalid    = rvalid_q;
	end

	// result formatting per status
	always_comb begin
		res_d.status = dp_cmd.emit_st;
		res_d.code   = '0;
		res_d.count  = COUNT_W'(cnt_q);
		res_d.last   = 1'b1;
		case (dp_cmd.emit_st)
			ST_LOGGED: res_d.count = COUNT_W'(cnt_q + CW'(1));
			ST_ENTRY: begin
				res_d.code = rdata;
				res_d.last = rlast_q;
			end
			ST_EMPTY, ST_CLEARED: res_d.count = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			rvalid_q <= 1'b0;
			strobe_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			rvalid_q <= dp_cmd.rd_issue;
			strobe_q <= dp_cmd.emit;
			if (dp_cmd.clr_cnt) begin
				cnt_q <= '0;
			end else if (dp_cmd.append) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (dp_cmd.capture) begin
				hit_q <= 1'b0;
			end else if (match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			code_q <= item.err_code;
		end
		if (dp_cmd.idx_scan) begin
			idx_q <= AW'(32'(cnt_q) - 32'(WINDOW));
		end else if (dp_cmd.idx_zero) begin
			idx_q <= '0;
		end else if (dp_cmd.rd_issue) begin
			idx_q <= idx_q + AW'(1);
		end
		if (dp_cmd.rd_issue) begin
			rlast_q <= dp_stat.at_end;
		end
		if (dp_cmd.emit) begin
			result_q <= res_d;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= 32'(DEPTH))
		else $error("stored count above depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.append |-> 32'(cnt_q) < 32'(DEPTH))
		else $error("append into a full store");

	a_read_stored: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.rd_issue |-> 32'(idx_q) < 32'(cnt_q))
		else $error("read beyond stored entries");

	a_entry_data: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.emit && dp_cmd.emit_st == ST_ENTRY) |-> rvalid_q)
		else $error("entry emitted without read data");

endmodule

/* hdl/eldb_ctrl.sv */
// eldb_ctrl: command sequencer for log, window scan, drain and clear
// depends on eldb_pkg
module eldb_ctrl
	import eldb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  eldb_stat_t dp_stat,
	output logic       busy,
	output eldb_cmd_t  dp_cmd
);

	eldb_state_t state_q, state_d;
	logic        accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_LOG && !dp_stat.code_zero && !dp_stat.full &&
					    dp_stat.gt_win) begin
						state_d = S_SCAN;
					end else if (cmd == CMD_DRAIN && !dp_stat.empty) begin
						state_d = S_DRAIN;
					end
				end
			end
			S_SCAN:      if (dp_stat.at_end) state_d = S_SCAN_FIN;
			S_SCAN_FIN:  state_d = S_IDLE;
			S_DRAIN:     if (dp_stat.at_end) state_d = S_DRAIN_END;
			S_DRAIN_END: state_d = S_IDLE;
			default:     state_d = S_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		dp_cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_LOG: begin
							dp_cmd.capture = 1'b1;
							if (dp_stat.code_zero) begin
								dp_cmd.emit    = 1'b1;
								dp_cmd.emit_st = ST_ZERO;
							end else if (dp_stat.full) begin
								dp_cmd.emit    = 1'b1;
								dp_cmd.emit_st = ST_FULL;
							end else if (dp_stat.gt_win) begin
								dp_cmd.idx_scan = 1'b1;
							end else begin
								dp_cmd.emit    = 1'b1;
								dp_cmd.emit_st = ST_LOGGED;
								dp_cmd.append  = 1'b1;
							end
						end
						CMD_DRAIN: begin
							if (dp_stat.empty) begin
								dp_cmd.emit    = 1'b1;
								dp_cmd.emit_st = ST_EMPTY;
							end else begin
								dp_cmd.idx_zero = 1'b1;
							end
						end
						CMD_CLEAR: begin
							dp_cmd.clr_cnt = 1'b1;
							dp_cmd.emit    = 1'b1;
							dp_cmd.emit_st = ST_CLEARED;
						end
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				dp_cmd.rd_issue = 1'b1;
			end
			S_SCAN_FIN: begin
				dp_cmd.emit    = 1'b1;
				dp_cmd.emit_st = dp_stat.dup ? ST_DUP : ST_LOGGED;
				dp_cmd.append  = !dp_stat.dup;
			end
			S_DRAIN: begin
				dp_cmd.rd_issue = 1'b1;
				dp_cmd.emit     = dp_stat.rvalid;
				dp_cmd.emit_st  = ST_ENTRY;
			end
			S_DRAIN_END: begin
				dp_cmd.emit    = 1'b1;
				dp_cmd.emit_st = ST_ENTRY;
				dp_cmd.clr_cnt = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

/* hdl/error_log_dedup_buffer_top.sv */
// error_log_dedup_buffer_top: error capture buffer with duplicate suppression
// depends on eldb_pkg, eldb_ctrl, eldb_datapath (which holds eldb_ram)
//
//  channel   handshake          payload      transfer when
//  -------   ---------          -------      -------------
//  command   start / busy       item         start high and busy low at clk rise
//  result    strobe             result       strobe high, one cycle, no stall
//
// zero code, full store, clear, empty drain and a log with WINDOW or fewer
//   codes stored: one result in the cycle after the transfer, busy stays low
// log with more than WINDOW codes stored: the window is read one entry a
//   cycle from the store ram while busy is high
// drain of n codes: one ram read a cycle, n results on consecutive cycles,
//   busy high through the drain, last result in the first cycle with busy low
// reset clears the stored count and the controller; store contents are
//   left as they are and only entries below the count are ever read
// the receiver cannot stall, so every result is shown for exactly one cycle
module error_log_dedup_buffer_top
	import eldb_pkg::*;
#(
	parameter int DEPTH  = 32,
	parameter int WINDOW = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  eldb_in_t  item,
	output logic      strobe,
	output eldb_out_t result
);

	// command and status between controller and datapath
	eldb_cmd_t  dp_cmd;
	eldb_stat_t dp_stat;

	// controller: sequences log, window scan, drain and clear
	eldb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (item.cmd),
		.dp_stat(dp_stat),
		.busy   (busy),
		.dp_cmd (dp_cmd)
	);

	// datapath: store ram, stored count, read index, compare, result register
	eldb_datapath #(
		.DEPTH (DEPTH),
		.WINDOW(WINDOW)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.dp_cmd (dp_cmd),
		.dp_stat(dp_stat),
		.strobe (strobe),
		.result (result)
	);

endmodule

/* verif/eldb_log_checker.sv */
// eldb_log_checker: watches the command and result channels of the error log buffer
// keeps its own copy of the stored codes, predicts every result and compares it
// depends on eldb_pkg
`timescale 1ns / 100ps

module eldb_log_checker
	import eldb_pkg::*;
#(
	parameter int DEPTH  = 32,
	parameter int WINDOW = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      busy,
	input  eldb_in_t  item,
	input  logic      strobe,
	input  eldb_out_t result,
	output int        error_count,
	output int        results_due
);

	logic signed [CODE_W-1:0] logged_codes [DEPTH];
	int                       codes_held;
	eldb_out_t                due_results [$];

	// work out the results of one accepted command and update the copy of the store
	task apply_command(input eldb_in_t cmd_item);
		eldb_out_t  r;
		logic [2:0] st;
		bit         hit;
		begin
			r      = '0;
			r.last = 1'b1;
			case (cmd_item.cmd)
				CMD_LOG: begin
					if (cmd_item.err_code == 0) begin
						st = ST_ZERO;
					end else if (codes_held >= DEPTH) begin
						st = ST_FULL;
					end else begin
						hit = 1'b0;
						// window check only once the store is past the window
						if (codes_held > WINDOW)
							for (int i = codes_held - WINDOW; i < codes_held; i++)
								if (logged_codes[i] == cmd_item.err_code)
									hit = 1'b1;
						if (hit) begin
							st = ST_DUP;
						end else begin
							logged_codes[codes_held] = cmd_item.err_code;
							codes_held++;
							st = ST_LOGGED;
						end
					end
					r.status = st;
					r.count  = codes_held[COUNT_W-1:0];
					due_results.push_back(r);
				end
				CMD_DRAIN: begin
					if (codes_held == 0) begin
						r.status = ST_EMPTY;
						due_results.push_back(r);
					end else begin
						for (int i = 0; i < codes_held; i++) begin
							r.status = ST_ENTRY;
							r.code   = logged_codes[i];
							r.count  = codes_held[COUNT_W-1:0];
							r.last   = (i == codes_held - 1);
							due_results.push_back(r);
						end
						codes_held = 0;
					end
				end
				CMD_CLEAR: begin
					codes_held = 0;
					r.status   = ST_CLEARED;
					due_results.push_back(r);
				end
				default: ;
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		eldb_out_t want;
		if (!arst_n) begin
			codes_held  = 0;
			error_count = 0;
			due_results.delete();
			results_due = 0;
		end else begin
			// results leave in the cycle after their command or later, so compare first
			if (strobe) begin
				if (due_results.size() == 0) begin
					$error("result with none due: status %0d code %0d count %0d last %0d",
						result.status, result.code, result.count, result.last);
					error_count++;
				end else begin
					want = due_results.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, result.status);
						error_count++;
					end
					if (result.code !== want.code) begin
						$error("code: expected %0d, actual %0d", want.code, result.code);
						error_count++;
					end
					if (result.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, result.count);
						error_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0d, actual %0d", want.last, result.last);
						error_count++;
					end
				end
			end
			if (start && !busy)
				apply_command(item);
			results_due = due_results.size();
		end
	end

endmodule

/* verif/tb_error_log_dedup_buffer_top.sv */
// tb_error_log_dedup_buffer_top: drives commands into the error log dedup buffer
// and gives the verdict; prediction and comparison live in eldb_log_checker
// depends on eldb_pkg, error_log_dedup_buffer_top, eldb_log_checker
`timescale 1ns / 100ps

module tb_error_log_dedup_buffer_top;
	import eldb_pkg::*;

	localparam int         DEPTH       = 32;
	localparam int         WINDOW      = 8;
	localparam int         ITEM_TARGET = 220;
	// past this many commands the sender stops pausing
	localparam int         QUIET_AFTER = 180;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	eldb_in_t  item;
	logic      strobe;
	eldb_out_t result;
	int        error_count;
	int        results_due;

	// commands that reached the block, unused ones left out
	int        sent;

	// small set of codes that come back again and again, so duplicates happen
	logic signed [CODE_W-1:0] repeat_codes [10] = '{
		-16'sd32768, 16'sd32767, 16'sd1, -16'sd1, 16'sd100,
		-16'sd100, 16'sd4660, -16'sd21846, 16'sd21845, 16'sd2
	};

	error_log_dedup_buffer_top #(
		.DEPTH  (DEPTH),
		.WINDOW (WINDOW)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.strobe (strobe),
		.result (result)
	);

	eldb_log_checker #(
		.DEPTH  (DEPTH),
		.WINDOW (WINDOW)
	) log_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.strobe      (strobe),
		.result      (result),
		.error_count (error_count),
		.results_due (results_due)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs or a result never comes
	initial begin
		#2_000_000;
		$display("tb_error_log_dedup_buffer_top NOT OK");
		$finish;
	end

	// one command transfer; called just after a falling edge and returns just
	// after the falling edge that follows the transfer, with start still high
	task automatic issue(input logic [1:0] op, input logic signed [CODE_W-1:0] value);
		eldb_in_t next_item;
		begin
			next_item.cmd      = op;
			next_item.err_code = value;
			start <= 1'b1;
			item  <= next_item;
			// busy is settled at the falling edge, so the transfer edge is known here
			while (busy)
				@(negedge clk);
			@(negedge clk);
			if (op != CMD_UNUSED)
				sent++;
		end
	endtask

	// random hold-off on the command side, none near the end
	task automatic maybe_pause();
		begin
			if (sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 8))
					@(negedge clk);
			end
		end
	endtask

	// mostly fresh full-range codes, a share of repeats and a few zeros
	function automatic logic signed [CODE_W-1:0] pick_code();
		int sel;
		begin
			sel = $urandom_range(0, 11);
			if (sel == 0)
				return '0;
			else if (sel <= 3)
				return repeat_codes[$urandom_range(0, 9)];
			else
				return CODE_W'($urandom);
		end
	endfunction

	initial begin
		int n_logs;

		// every input known from time zero
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		sent   = 0;
		repeat (6)
			@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part
		issue(CMD_DRAIN, 16'sd0);          // drain of an empty store
		issue(CMD_CLEAR, 16'sd0);          // clear of an empty store
		issue(CMD_LOG, 16'sd0);            // zero code is ignored
		issue(CMD_LOG, -16'sd32768);       // most negative code
		issue(CMD_LOG, 16'sd32767);        // most positive code
		issue(CMD_LOG, 16'sd1);
		issue(CMD_LOG, -16'sd1);           // all ones
		issue(CMD_UNUSED, -16'sd1);        // unused command, no result at all
		issue(CMD_LOG, 16'sd21845);
		issue(CMD_LOG, -16'sd21846);
		issue(CMD_LOG, 16'sd7);
		issue(CMD_LOG, 16'sd9);            // eighth code stored
		issue(CMD_LOG, 16'sd9);            // window not yet passed: no duplicate check
		issue(CMD_LOG, 16'sd9);            // past the window now: duplicate
		issue(CMD_LOG, 16'sd1);            // also inside the window: duplicate
		issue(CMD_LOG, -16'sd32768);       // oldest code has left the window: logged
		issue(CMD_LOG, -16'sd32768);       // duplicate of the newest code
		issue(CMD_DRAIN, 16'sd0);          // drain of several codes
		issue(CMD_DRAIN, 16'sd0);          // store empty again
		issue(CMD_LOG, 16'sd3);
		issue(CMD_CLEAR, -16'sd1);         // clear with a stored code, field ignored
		issue(CMD_DRAIN, 16'sd5);          // nothing left after the clear

		// random part: fill runs of random length, each closed by a drain or a clear;
		// long runs push the store to full, pauses land on scans and drains
		while (sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				n_logs = $urandom_range(36, 50);
			else
				n_logs = $urandom_range(1, 20);
			for (int i = 0; i < n_logs; i++) begin
				maybe_pause();
				case ($urandom_range(0, 39))
					0:       issue(CMD_UNUSED, CODE_W'($urandom));
					1:       issue(CMD_DRAIN, CODE_W'($urandom));
					2:       issue(CMD_CLEAR, CODE_W'($urandom));
					default: issue(CMD_LOG, pick_code());
				endcase
			end
			maybe_pause();
			if ($urandom_range(0, 3) == 0)
				issue(CMD_CLEAR, CODE_W'($urandom));
			else
				issue(CMD_DRAIN, CODE_W'($urandom));
			// now and then a second drain right away finds the store empty
			if ($urandom_range(0, 7) == 0)
				issue(CMD_DRAIN, CODE_W'($urandom));
		end
		start <= 1'b0;

		// wait for every due result, then wait on for any stray one
		while (results_due != 0)
			@(negedge clk);
		repeat (2 * WINDOW + 4)
			@(negedge clk);

		if (error_count == 0 && results_due == 0)
			$display("tb_error_log_dedup_buffer_top OK");
		else
			$display("tb_error_log_dedup_buffer_top NOT OK");
		$finish;
	end

endmodule
